[hdl/mmc_pkg.sv]
// Shared types and constants for the magnetometer min/max calibration core.
package mmc_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned CAL_W     = 20;
  localparam int unsigned SPAN_W    = 16;  // max - min always fits unsigned 16 bits
  localparam int unsigned SUM_W     = 18;  // sum of three spans
  localparam int unsigned NUM_W     = 18;  // 2*raw - (min+max), signed
  localparam int unsigned DVSR_W    = 19;  // 6*span
  localparam int unsigned PROD_W    = SPAN_W + SUM_W;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned DVD_W     = PROD_W + FRAC_BITS;
  localparam int unsigned QUO_W     = CAL_W - 1;  // quotient magnitude bits
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned AX_W      = $clog2(NUM_AXES);

  localparam logic signed [RAW_W-1:0] AXIS_MAX_RST = 16'sh8000;
  localparam logic signed [RAW_W-1:0] AXIS_MIN_RST = 16'sh7fff;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] cal_x;
    logic signed [CAL_W-1:0] cal_y;
    logic signed [CAL_W-1:0] cal_z;
    logic                    recalibrated;
    logic                    degenerate;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_e;

  // Datapath strobes decoded from the sequencer state
  typedef struct packed {
    logic capture;
    logic update;
    logic sum;
    logic prep;
    logic mul;
    logic div;
    logic store;
    logic load_out;
  } ctl_t;

endpackage

[hdl/mmc_in_if.sv]
// Sample channel: valid/ready handshake with a three-axis raw sample payload.
interface mmc_in_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/mmc_out_if.sv]
// Result channel: valid/ready handshake with the calibrated three-axis result.
interface mmc_out_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/magnetometer_minmax_calibration_core.sv]
// An axis with zero span skips the multiply and divide, stores zero and marks the result degenerate.
// A new sample is taken only when idle.
// The division is done by one restoring divider, 38 steps per axis, shared by all three axes.
// A finished result waits in an output register, so the next sample can start meanwhile.
// Reset: per-axis max goes to -32768, min to 32767, sequencer idle, no result pending.
module magnetometer_minmax_calibration_core import mmc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  mmc_in_if.sink     in_i,
  mmc_out_if.source  out_o
);

  // Sequencer and control
  state_e              state_q, state_d;
  ctl_t                ctl;
  logic [AX_W-1:0]     ax_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                last_ax;

  // Per-axis storage
  logic signed [RAW_W-1:0] raw_q [NUM_AXES];
  logic signed [RAW_W-1:0] max_q [NUM_AXES];
  logic signed [RAW_W-1:0] min_q [NUM_AXES];
  logic signed [CAL_W-1:0] cal_q [NUM_AXES];
  logic [NUM_AXES-1:0]     upd_hi, upd_lo;
  logic                    recal_q, degen_q;

  // Shared arithmetic registers
  logic [SUM_W-1:0]        sum_q;
  logic [SPAN_W-1:0]       mag_q;
  logic                    neg_q;
  logic [DVSR_W-1:0]       dvsr_q;
  logic [DVD_W-1:0]        quo_q;
  logic [DVSR_W-1:0]       rem_q;

  // Output register
  logic                    out_valid_q;
  result_t                 out_q;

  // Current-axis combinational terms
  logic signed [RAW_W:0]   span_full;
  logic [SPAN_W-1:0]       span_cur;
  logic                    span_zero;
  logic signed [NUM_W-1:0] num_cur;
  logic [NUM_W-1:0]        num_abs;
  logic [SPAN_W-1:0]       spans [NUM_AXES];
  logic [PROD_W-1:0]       prod;
  logic [DVSR_W:0]         rem_sh;
  logic                    div_ge;
  logic [DVSR_W:0]         rem_sub;
  logic [CAL_W-1:0]        quo_mag;

  assign last_ax = (ax_q == AX_W'(NUM_AXES - 1));

  // Span and centered numerator of the axis being worked on
  always_comb begin
    span_full = (RAW_W+1)'(max_q[ax_q]) - (RAW_W+1)'(min_q[ax_q]);
    span_cur  = span_full[SPAN_W-1:0];
    span_zero = (span_cur == '0);
    num_cur   = $signed({raw_q[ax_q][RAW_W-1], raw_q[ax_q], 1'b0})
              - (NUM_W'(min_q[ax_q]) + NUM_W'(max_q[ax_q]));
    num_abs   = num_cur[NUM_W-1] ? NUM_W'(-num_cur) : NUM_W'(num_cur);
  end

  // Span of every axis, used for the sum
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      spans[a] = SPAN_W'((RAW_W+1)'(max_q[a]) - (RAW_W+1)'(min_q[a]));
    end
  end

  // Range compare lanes
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      upd_hi[a] = (raw_q[a] > max_q[a]);
      upd_lo[a] = (raw_q[a] < min_q[a]);
    end
  end

  // Divider step and multiplier
  assign prod    = PROD_W'(mag_q) * PROD_W'(sum_q);
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvsr_q});
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  assign quo_mag = {1'b0, quo_q[QUO_W-1:0]};

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_PREP;
      ST_PREP: begin
        if (!span_zero)   state_d = ST_MUL;
        else if (last_ax) state_d = ST_DONE;
        else              state_d = ST_PREP;
      end
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_STORE;
      ST_STORE:  state_d = last_ax ? ST_DONE : ST_PREP;
      ST_DONE:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    ctl        = '0;
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready  = 1'b1;
        ctl.capture = in_i.valid;
      end
      ST_UPDATE: ctl.update   = 1'b1;
      ST_SUM:    ctl.sum      = 1'b1;
      ST_PREP:   ctl.prep     = 1'b1;
      ST_MUL:    ctl.mul      = 1'b1;
      ST_DIV:    ctl.div      = 1'b1;
      ST_STORE:  ctl.store    = 1'b1;
      ST_DONE:   ctl.load_out = !out_valid_q || out_o.ready;
      default:   ctl          = '0;
    endcase
  end

  // Sequencer, counters and min/max tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
      cnt_q   <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        max_q[a] <= AXIS_MAX_RST;
        min_q[a] <= AXIS_MIN_RST;
      end
    end else begin
      state_q <= state_d;
      if (ctl.capture) ax_q <= '0;
      if ((ctl.prep && span_zero && !last_ax) || (ctl.store && !last_ax)) begin
        ax_q <= ax_q + AX_W'(1);
      end
      if (ctl.mul) cnt_q <= '0;
      if (ctl.div) cnt_q <= cnt_q + CNT_W'(1);
      if (ctl.update) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (upd_hi[a]) max_q[a] <= raw_q[a];
          if (upd_lo[a]) min_q[a] <= raw_q[a];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl.capture) begin
      raw_q[0] <= in_i.data.raw_x;
      raw_q[1] <= in_i.data.raw_y;
      raw_q[2] <= in_i.data.raw_z;
      degen_q  <= 1'b0;
    end
    if (ctl.update) recal_q <= |{upd_hi, upd_lo};
    if (ctl.sum) begin
      sum_q <= SUM_W'(spans[0]) + SUM_W'(spans[1]) + SUM_W'(spans[2]);
    end
    if (ctl.prep) begin
      mag_q  <= num_abs[SPAN_W-1:0];
      neg_q  <= num_cur[NUM_W-1];
      dvsr_q <= (DVSR_W'(span_cur) << 2) + (DVSR_W'(span_cur) << 1);
      if (span_zero) begin
        cal_q[ax_q] <= '0;
        degen_q     <= 1'b1;
      end
    end
    if (ctl.mul) begin
      quo_q <= {prod, FRAC_BITS'(0)};
      rem_q <= '0;
    end
    if (ctl.div) begin
      quo_q <= {quo_q[DVD_W-2:0], div_ge};
      rem_q <= div_ge ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
    end
    if (ctl.store) begin
      cal_q[ax_q] <= neg_q ? $signed(-quo_mag) : $signed(quo_mag);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_out) begin
      out_q.cal_x        <= cal_q[0];
      out_q.cal_y        <= cal_q[1];
      out_q.cal_z        <= cal_q[2];
      out_q.recalibrated <= recal_q;
      out_q.degenerate   <= degen_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Once past the update, every stored sample lies inside its axis range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP || state_q == ST_MUL || state_q == ST_DIV || state_q == ST_STORE)
      |-> (raw_q[0] <= max_q[0] && raw_q[0] >= min_q[0] &&
           raw_q[1] <= max_q[1] && raw_q[1] >= min_q[1] &&
           raw_q[2] <= max_q[2] && raw_q[2] >= min_q[2]))
    else $error("sample outside its min/max range after update");

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dvsr_q))
    else $error("divider remainder not below divisor");

  // Quotient magnitude fits the result width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |-> (quo_q[DVD_W-1:QUO_W] == '0))
    else $error("quotient overflows result width");

  // A result only appears at the end of a sample's work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside the done step");

endmodule
